// ----- design/meg_pkg.sv -----
package meg_pkg;

	// Field widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 16;
	localparam int AMP_W      = 16;
	localparam int MODE_W     = 2;
	localparam int REQ_W      = 2;
	localparam int DELTA_W    = 24;
	localparam int TGT_W      = 8;

	// Mode bits
	localparam int MODE_FREEZE_BIT      = 0;
	localparam int MODE_NO_BLENDOUT_BIT = 1;

	// Serial multiplier: 33 x 16 bits, one multiplier bit a step
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 16;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = 4;

	// Serial divider: 49-bit dividend, 32-bit divisor, 17 quotient bits
	localparam int DIV_N_W   = MUL_P_W;
	localparam int DIV_D_W   = 32;
	localparam int DIV_Q_W   = DIV_N_W - DIV_D_W;
	localparam int DIV_CNT_W = 5;

	localparam logic signed [AMP_W-1:0] BLEND_MAX = 16'sh7FFF;
	localparam logic signed [AMP_W-1:0] BLEND_MIN = 16'sh8000;

	localparam logic signed [AMP_W-1:0] AMP_RESET   = 16'sd4096;
	localparam logic [SPEED_W-1:0]      SPEED_RESET = 16'd256;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_TIME = 3'd0,
		CFG_SPEED      = 3'd1,
		CFG_BLEND_IN   = 3'd2,
		CFG_HOLD       = 3'd3,
		CFG_BLEND_OUT  = 3'd4,
		CFG_AMPLITUDE  = 3'd5,
		CFG_MODE       = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_res_t;

	typedef struct packed {
		logic               done;
		logic               ovf;
		logic [DIV_Q_W-1:0] quo;
	} div_res_t;

endpackage

// ----- design/meg_if.sv -----
interface meg_req_if;
	logic                         valid;
	logic                         ready;
	logic [meg_pkg::REQ_W-1:0]    req_type;
	logic [meg_pkg::DELTA_W-1:0]  delta_time;
	logic [meg_pkg::TGT_W-1:0]    target_id;

	modport source (output valid, req_type, delta_time, target_id, input ready);
	modport sink   (input valid, req_type, delta_time, target_id, output ready);
endinterface

interface meg_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               active;
	logic [meg_pkg::TGT_W-1:0]          cur_target;
	logic signed [meg_pkg::AMP_W-1:0]   blending;

	modport source (output valid, active, cur_target, blending, input ready);
	modport sink   (input valid, active, cur_target, blending, output ready);
endinterface

// ----- design/meg_mul.sv -----
module meg_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [meg_pkg::MUL_A_W-1:0]   a,
	input  logic [meg_pkg::MUL_B_W-1:0]   b,
	output meg_pkg::mul_res_t             res
);

	logic [meg_pkg::MUL_A_W-1:0]   a_q;
	logic [meg_pkg::MUL_P_W-1:0]   p_q;
	logic [meg_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          done_q;
	logic [meg_pkg::MUL_A_W:0]     sum;

	// Add the multiplicand into the top when the low bit is set, then shift right
	assign sum = {1'b0, p_q[meg_pkg::MUL_P_W-1:meg_pkg::MUL_B_W]}
		+ {1'b0, (p_q[0] ? a_q : '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == meg_pkg::MUL_CNT_W'(meg_pkg::MUL_B_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			p_q <= {{meg_pkg::MUL_A_W{1'b0}}, b};
		end else if (run_q) begin
			p_q <= {sum, p_q[meg_pkg::MUL_B_W-1:1]};
		end
	end

	assign res.done = done_q;
	assign res.prod = p_q;

endmodule

// ----- design/meg_div.sv -----
module meg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [meg_pkg::DIV_N_W-1:0]   n,
	input  logic [meg_pkg::DIV_D_W-1:0]   d,
	output meg_pkg::div_res_t             res
);

	logic [meg_pkg::DIV_D_W-1:0]   r_q;
	logic [meg_pkg::DIV_D_W-1:0]   d_q;
	logic [meg_pkg::DIV_Q_W-1:0]   s_q;
	logic [meg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          done_q;
	logic                          ovf_q;
	logic [meg_pkg::DIV_D_W:0]     rs;
	logic [meg_pkg::DIV_D_W:0]     rd;
	logic                          ge;

	// Restoring step: bring down the next dividend bit, subtract when it fits
	assign rs = {r_q, s_q[meg_pkg::DIV_Q_W-1]};
	assign ge = rs >= {1'b0, d_q};
	assign rd = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == meg_pkg::DIV_CNT_W'(meg_pkg::DIV_Q_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (go) begin
			r_q   <= n[meg_pkg::DIV_N_W-1:meg_pkg::DIV_Q_W];
			s_q   <= n[meg_pkg::DIV_Q_W-1:0];
			d_q   <= d;
			ovf_q <= n[meg_pkg::DIV_N_W-1:meg_pkg::DIV_Q_W] >= d;
		end else if (run_q) begin
			r_q <= ge ? rd[meg_pkg::DIV_D_W-1:0] : rs[meg_pkg::DIV_D_W-1:0];
			s_q <= {s_q[meg_pkg::DIV_Q_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = s_q;

endmodule

// ----- design/morph_envelope_generator_unit.sv -----
// Channel  Dir  Contents                                  Handshake
// req      in   req_type, delta_time, target_id           valid/ready
// rsp      out  active, cur_target, blending              valid/ready
// cfg      in   cfg_wr_en, cfg_index, cfg_data            write enable only
//
// One request at a time. Start, stop and flat envelope sections pass through S_SUM, S_EVAL
// and S_OUT; a tick that advances time first runs a serial multiply in S_MUL1, and a point
// on a ramp adds a serial multiply, then a serial divide (S_MUL2, S_DIV).
// The 16-step shift-add multiplier is used twice and the 17-step restoring divider once
// in the worst case. Reset clears the envelope and loads the register defaults.
// A waiting result blocks nothing until the next result is due; that one holds in S_OUT.
module morph_envelope_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [meg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [meg_pkg::CFG_DATA_W-1:0]  cfg_data,
	meg_req_if.sink                         req,
	meg_rsp_if.source                       rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_SUM,
		S_EVAL,
		S_MUL2,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;

	logic [meg_pkg::TIME_W-1:0]         start_time_q;
	logic [meg_pkg::SPEED_W-1:0]        speed_q;
	logic [meg_pkg::TIME_W-1:0]         blend_in_q;
	logic [meg_pkg::TIME_W-1:0]         hold_q;
	logic [meg_pkg::TIME_W-1:0]         blend_out_q;
	logic signed [meg_pkg::AMP_W-1:0]   amp_q;
	logic [meg_pkg::MODE_W-1:0]         mode_q;

	logic [meg_pkg::TIME_W-1:0]         env_time_q;
	logic                               running_q;
	logic [meg_pkg::TGT_W-1:0]          held_target_q;
	logic                               tick_q;
	logic [meg_pkg::TIME_W:0]           bih_q;
	logic [meg_pkg::TIME_W+1:0]         endsum_q;
	logic [meg_pkg::DIV_D_W-1:0]        div_d_q;
	logic                               neg_q;
	logic signed [meg_pkg::AMP_W-1:0]   blend_q;
	logic                               mul_go_q;
	logic [meg_pkg::MUL_A_W-1:0]        mul_a_q;
	logic [meg_pkg::MUL_B_W-1:0]        mul_b_q;
	logic                               div_go_q;
	logic                               rsp_valid_q;
	logic                               rsp_active_q;
	logic [meg_pkg::TGT_W-1:0]          rsp_target_q;
	logic signed [meg_pkg::AMP_W-1:0]   rsp_blend_q;

	meg_pkg::mul_res_t                  mul_res;
	meg_pkg::div_res_t                  div_res;

	logic [meg_pkg::TIME_W:0]           t_sum;
	logic [meg_pkg::TIME_W+2:0]         diff;
	logic [meg_pkg::TIME_W+2:0]         diff_abs;
	logic [meg_pkg::AMP_W-1:0]          amp_mag;
	logic                               out_free;
	logic                               no_blendout;
	logic                               big_neg;
	logic                               big_pos;
	logic signed [meg_pkg::AMP_W-1:0]   sat_val;
	logic                               tick_go;
	logic                               eval_end;
	logic                               eval_rise;
	logic                               eval_flat;
	logic                               eval_mul;

	meg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.res    (mul_res)
	);

	meg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.n      (mul_res.prod),
		.d      (div_d_q),
		.res    (div_res)
	);

	// Time advance: (delta * speed) >> 8, saturating add
	assign t_sum = {1'b0, env_time_q} + {1'b0, mul_res.prod[meg_pkg::TIME_W+7:8]};

	// Remaining blend-out time, signed: end of envelope minus current time
	assign diff     = {1'b0, endsum_q} - {3'b000, env_time_q};
	assign diff_abs = diff[meg_pkg::TIME_W+2] ? (~diff + 1'b1) : diff;
	assign amp_mag  = amp_q[meg_pkg::AMP_W-1] ? (~amp_q + 1'b1) : amp_q;

	assign no_blendout = mode_q[meg_pkg::MODE_NO_BLENDOUT_BIT];
	assign out_free    = !rsp_valid_q || rsp.ready;

	// Tick on a running envelope with time not frozen: start the time multiply
	assign tick_go = req.valid && (req.req_type == meg_pkg::REQ_TICK) && running_q
		&& !mode_q[meg_pkg::MODE_FREEZE_BIT];

	assign eval_end  = tick_q && !no_blendout && ({2'b00, env_time_q} > endsum_q);
	assign eval_rise = env_time_q < blend_in_q;
	assign eval_flat = no_blendout || ({1'b0, env_time_q} < bih_q);
	assign eval_mul  = running_q && !eval_end
		&& (eval_rise || (!eval_flat && (blend_out_q != '0)));

	assign big_neg = div_res.ovf || (div_res.quo > meg_pkg::DIV_Q_W'(32768));
	assign big_pos = div_res.ovf || (div_res.quo > meg_pkg::DIV_Q_W'(32767));

	always_comb begin
		if (neg_q) begin
			sat_val = big_neg ? meg_pkg::BLEND_MIN : (~div_res.quo[meg_pkg::AMP_W-1:0] + 1'b1);
		end else begin
			sat_val = big_pos ? meg_pkg::BLEND_MAX : div_res.quo[meg_pkg::AMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			speed_q      <= meg_pkg::SPEED_RESET;
			blend_in_q   <= '0;
			hold_q       <= '0;
			blend_out_q  <= '0;
			amp_q        <= meg_pkg::AMP_RESET;
			mode_q       <= '0;
		end else if (cfg_wr_en) begin
			unique case (meg_pkg::cfg_idx_t'(cfg_index))
				meg_pkg::CFG_START_TIME: start_time_q <= cfg_data;
				meg_pkg::CFG_SPEED:      speed_q      <= cfg_data[meg_pkg::SPEED_W-1:0];
				meg_pkg::CFG_BLEND_IN:   blend_in_q   <= cfg_data;
				meg_pkg::CFG_HOLD:       hold_q       <= cfg_data;
				meg_pkg::CFG_BLEND_OUT:  blend_out_q  <= cfg_data;
				meg_pkg::CFG_AMPLITUDE:  amp_q        <= signed'(cfg_data[meg_pkg::AMP_W-1:0]);
				meg_pkg::CFG_MODE:       mode_q       <= cfg_data[meg_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			env_time_q    <= '0;
			running_q     <= 1'b0;
			held_target_q <= '0;
			tick_q        <= 1'b0;
			mul_go_q      <= 1'b0;
			div_go_q      <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_active_q  <= 1'b0;
			rsp_target_q  <= '0;
			rsp_blend_q   <= '0;
			bih_q         <= '0;
			endsum_q      <= '0;
			div_d_q       <= '0;
			neg_q         <= 1'b0;
			blend_q       <= '0;
			mul_a_q       <= '0;
			mul_b_q       <= '0;
		end else begin
			mul_go_q <= ((state_q == S_IDLE) && tick_go) || ((state_q == S_EVAL) && eval_mul);
			div_go_q <= (state_q == S_MUL2) && mul_res.done;
			if ((state_q == S_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						tick_q <= (req.req_type == meg_pkg::REQ_TICK) && running_q;
						bih_q  <= {1'b0, blend_in_q} + {1'b0, hold_q};
						if (tick_go) begin
							mul_a_q <= {{(meg_pkg::MUL_A_W - meg_pkg::DELTA_W){1'b0}},
								req.delta_time};
							mul_b_q <= speed_q;
							state_q <= S_MUL1;
						end else begin
							state_q <= S_SUM;
						end
						unique case (meg_pkg::req_code_t'(req.req_type))
							meg_pkg::REQ_START: begin
								running_q     <= 1'b1;
								held_target_q <= req.target_id;
								env_time_q    <= start_time_q;
							end
							meg_pkg::REQ_STOP: begin
								running_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_MUL1: begin
					if (mul_res.done) begin
						env_time_q <= t_sum[meg_pkg::TIME_W] ? '1 : t_sum[meg_pkg::TIME_W-1:0];
						state_q    <= S_SUM;
					end
				end
				S_SUM: begin
					endsum_q <= {1'b0, bih_q} + {2'b00, blend_out_q};
					state_q  <= S_EVAL;
				end
				S_EVAL: begin
					priority if (!running_q) begin
						blend_q <= '0;
						state_q <= S_OUT;
					end else if (eval_end) begin
						// past the end of the blend-out: drop the envelope
						running_q <= 1'b0;
						blend_q   <= '0;
						state_q   <= S_OUT;
					end else if (eval_rise) begin
						mul_a_q <= {1'b0, env_time_q};
						mul_b_q <= amp_mag;
						div_d_q <= blend_in_q;
						neg_q   <= amp_q[meg_pkg::AMP_W-1];
						state_q <= S_MUL2;
					end else if (eval_flat) begin
						blend_q <= amp_q;
						state_q <= S_OUT;
					end else if (blend_out_q == '0) begin
						blend_q <= '0;
						state_q <= S_OUT;
					end else begin
						mul_a_q <= diff_abs[meg_pkg::MUL_A_W-1:0];
						mul_b_q <= amp_mag;
						div_d_q <= blend_out_q;
						neg_q   <= amp_q[meg_pkg::AMP_W-1] ^ diff[meg_pkg::TIME_W+2];
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_res.done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						blend_q <= sat_val;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_active_q <= running_q;
						rsp_target_q <= running_q ? held_target_q : '0;
						rsp_blend_q  <= blend_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.active     = rsp_active_q;
	assign rsp.cur_target = rsp_target_q;
	assign rsp.blending   = rsp_blend_q;

`ifndef NO_ASSERTIONS
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.active) |-> (rsp.blending == '0 && rsp.cur_target == '0))
		else $error("inactive result carries a non-zero value");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_res.done |-> (state_q == S_MUL1 || state_q == S_MUL2))
		else $error("multiplier finished outside a multiply state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while the previous one is in flight");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1 && mul_res.done) |=> (env_time_q >= $past(env_time_q)))
		else $error("time advance moved the envelope time backwards");
`endif

endmodule
